### sv/min_sum_message_update_macros.svh
// Assertion macros for the min-sum message update RTL.
`ifndef MIN_SUM_MESSAGE_UPDATE_MACROS_SVH
`define MIN_SUM_MESSAGE_UPDATE_MACROS_SVH

// Combinational or implication property sampled on clk, off during reset.
`define MSMU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define MSMU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/msmu_pkg.sv
// Types, constants and helpers shared by the min-sum message update block.
package msmu_pkg;

	localparam int MAX_LABELS = 16;
	localparam int BUF_DEPTH  = 16;
	localparam int IDX_W      = 4;
	localparam int CNT_W      = 5;
	localparam int COST_W     = 32;
	localparam int WEIGHT_W   = 16;
	localparam int PEN_W      = WEIGHT_W + IDX_W;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_WEIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LABELS_IN_USE = 2'd1;

	localparam logic [WEIGHT_W-1:0] SMOOTH_WEIGHT_RST = 16'd100;
	localparam logic [CNT_W-1:0]    LABELS_RST        = 5'd13;

	localparam logic [1:0] DIR_LEFT  = 2'd0;
	localparam logic [1:0] DIR_RIGHT = 2'd1;
	localparam logic [1:0] DIR_UP    = 2'd2;
	localparam logic [1:0] DIR_DOWN  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD1,
		ST_ADD2,
		ST_STORE,
		ST_SCAN,
		ST_EMIT
	} msmu_state_t;

	typedef struct packed {
		logic capture;
		logic add1;
		logic add2;
		logic store;
		logic scan_start;
		logic scan;
		logic next_label;
	} msmu_cmd_t;

	typedef struct packed {
		logic last_label;
		logic scan_done;
		logic last_entry;
	} msmu_status_t;

	// Labels in force: clamp to [2, min(MAX_LABELS, BUF_DEPTH)].
	function automatic logic [CNT_W-1:0] label_count(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] cap;
		cap = (MAX_LABELS < BUF_DEPTH) ? CNT_W'(MAX_LABELS) : CNT_W'(BUF_DEPTH);
		if (v < 5'd2)
			return 5'd2;
		else if (v > cap)
			return cap;
		else
			return v;
	endfunction

endpackage

### sv/min_sum_message_update.sv
// Top level of the min-sum belief propagation message update block.
// One request per label, in label order; each is captured, summed in two add steps and
// stored as its h value. The request for the last label starts the message: for each
// output label the single shared add/compare unit walks all n stored h values, and
// each result is held until it is taken (n = labels in force, 2..16). No new request
// is taken until the last entry is taken.
module min_sum_message_update import msmu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WEIGHT_W-1:0]  cfg_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [159:0]         s_axis_tdata,  // data_cost, msg_left, msg_right, msg_up, msg_down
	input  logic [1:0]           s_axis_tuser,  // out_direction
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [31:0]          m_axis_tdata,  // message_value
	output logic [3:0]           m_axis_tuser,  // label_index
	output logic                 m_axis_tlast   // last_entry
);

	msmu_cmd_t    cmd;
	msmu_status_t status;

	assign cfg_ready = 1'b1;

	msmu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	msmu_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_direction (s_axis_tuser),
		.data_cost     (s_axis_tdata[31:0]),
		.msg_left      (s_axis_tdata[63:32]),
		.msg_right     (s_axis_tdata[95:64]),
		.msg_up        (s_axis_tdata[127:96]),
		.msg_down      (s_axis_tdata[159:128]),
		.cmd           (cmd),
		.status        (status),
		.label_index   (m_axis_tuser),
		.message_value (m_axis_tdata),
		.last_entry    (m_axis_tlast)
	);

endmodule

### sv/msmu_dp.sv
// Datapath: config registers, cost accumulation, h buffer and min-plus scan.
module msmu_dp import msmu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WEIGHT_W-1:0]  cfg_data,
	input  logic [1:0]           out_direction,
	input  logic [COST_W-1:0]    data_cost,
	input  logic [COST_W-1:0]    msg_left,
	input  logic [COST_W-1:0]    msg_right,
	input  logic [COST_W-1:0]    msg_up,
	input  logic [COST_W-1:0]    msg_down,
	input  msmu_cmd_t            cmd,
	output msmu_status_t         status,
	output logic [IDX_W-1:0]     label_index,
	output logic [COST_W-1:0]    message_value,
	output logic                 last_entry
);

	logic [WEIGHT_W-1:0] weight_q;
	logic [CNT_W-1:0]    labels_q;
	logic [IDX_W-1:0]    label_counter_q;
	logic [IDX_W-1:0]    i_q;
	logic [CNT_W-1:0]    j_q;
	logic                v_s1;
	logic                v_s2;

	logic [COST_W-1:0]   dc_q, ml_q, mr_q, mu_q, md_q;
	logic [COST_W-1:0]   sum_a_q, sum_b_q, sum_c_q;
	logic [COST_W-1:0]   mem [BUF_DEPTH];
	logic [COST_W-1:0]   rdata_s1;
	logic [PEN_W-1:0]    pen_s1;
	logic [COST_W-1:0]   p_s2;
	logic [COST_W-1:0]   best_q;

	logic [CNT_W-1:0]    n;
	logic                issue;
	logic [IDX_W-1:0]    j_idx;
	logic [IDX_W-1:0]    label_dist;

	assign n          = label_count(labels_q);
	assign j_idx      = j_q[IDX_W-1:0];
	assign issue      = cmd.scan && (j_q < n);
	assign label_dist = (i_q > j_idx) ? (i_q - j_idx) : (j_idx - i_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= SMOOTH_WEIGHT_RST;
			labels_q <= LABELS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SMOOTH_WEIGHT: weight_q <= cfg_data;
				REG_LABELS_IN_USE: labels_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			label_counter_q <= '0;
			i_q             <= '0;
			j_q             <= '0;
			v_s1            <= 1'b0;
			v_s2            <= 1'b0;
		end else begin
			if (cmd.store) begin
				if (status.last_label) begin
					label_counter_q <= '0;
					i_q             <= '0;
				end else begin
					label_counter_q <= label_counter_q + 1'b1;
				end
			end
			if (cmd.next_label)
				i_q <= i_q + 1'b1;
			if (cmd.scan_start) begin
				j_q  <= '0;
				v_s1 <= 1'b0;
				v_s2 <= 1'b0;
			end else if (cmd.scan) begin
				v_s1 <= issue;
				v_s2 <= v_s1;
				if (issue)
					j_q <= j_q + 1'b1;
			end
		end
	end

	// h = data cost plus the three messages not from the send side
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			dc_q <= data_cost;
			ml_q <= (out_direction != DIR_LEFT)  ? msg_left  : '0;
			mr_q <= (out_direction != DIR_RIGHT) ? msg_right : '0;
			mu_q <= (out_direction != DIR_UP)    ? msg_up    : '0;
			md_q <= (out_direction != DIR_DOWN)  ? msg_down  : '0;
		end
		if (cmd.add1) begin
			sum_a_q <= dc_q + ml_q;
			sum_b_q <= mr_q + mu_q;
			sum_c_q <= md_q;
		end
		if (cmd.add2)
			sum_a_q <= sum_a_q + sum_b_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.store)
			mem[label_counter_q] <= sum_a_q + sum_c_q;
		if (issue)
			rdata_s1 <= mem[j_idx];
	end

	always_ff @(posedge clk) begin
		if (issue)
			pen_s1 <= PEN_W'(weight_q) * PEN_W'(label_dist);
		if (v_s1)
			p_s2 <= rdata_s1 + COST_W'(pen_s1);
		if (cmd.scan_start)
			best_q <= '1;
		else if (cmd.scan && v_s2 && (p_s2 < best_q))
			best_q <= p_s2;
	end

	assign status.last_label = ({1'b0, label_counter_q} + 5'd1) >= n;
	assign status.scan_done  = (j_q >= n) && !v_s1 && !v_s2;
	assign status.last_entry = ({1'b0, i_q} + 5'd1) == n;

	assign label_index   = i_q;
	assign message_value = best_q;
	assign last_entry    = status.last_entry;

endmodule

### sv/msmu_ctrl.sv
// Controller: sequences load, accumulate, store, scan and emit of each message.
module msmu_ctrl import msmu_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  msmu_status_t status,
	output msmu_cmd_t    cmd
);

	`include "min_sum_message_update_macros.svh"

	msmu_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_ADD1;
				end
			end
			ST_ADD1: begin
				cmd.add1 = 1'b1;
				state_d  = ST_ADD2;
			end
			ST_ADD2: begin
				cmd.add2 = 1'b1;
				state_d  = ST_STORE;
			end
			ST_STORE: begin
				cmd.store = 1'b1;
				if (status.last_label) begin
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_done)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (status.last_entry) begin
						state_d = ST_IDLE;
					end else begin
						cmd.next_label = 1'b1;
						cmd.scan_start = 1'b1;
						state_d        = ST_SCAN;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`MSMU_ASSERT(a_no_overlap, !(in_ready && out_valid), "request taken while result pending")
	`MSMU_ASSERT_NEXT(a_last_to_idle, out_valid && out_ready && status.last_entry, in_ready, "no return to idle after last entry")
	`MSMU_ASSERT_NEXT(a_next_scan, out_valid && out_ready && !status.last_entry, state_q == ST_SCAN, "no rescan after entry")

endmodule
